/* hw/rtl/rps_pkg.sv */
// Shared constants and types for the random permutation sampler.
package rps_pkg;

	// Field widths fixed by the interface.
	localparam int WORD_W = 16;
	localparam int CFG_W  = 7;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 6;

	// Default store depth and reset entry count.
	localparam int N_DEFAULT   = 64;
	localparam int NACT_RESET  = 64;
	localparam int NACT_MIN    = 2;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Size of the random word range; a word is rejected when its
	// quotient block would run past this value.
	localparam logic [WORD_W:0] WORD_RANGE = 17'h10000;

	// One accepted draw on its way to the store.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		logic             is_last;
	} qitem_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* hw/rtl/rps_front.sv */
// Front end: takes random words, reduces them modulo the bound and rejects biased words.
module rps_front #(
	parameter int N = rps_pkg::N_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rps_pkg::WORD_W-1:0]    rnd_word,
	input  logic                          cfg_we,
	input  logic [$clog2(N+1)-1:0]        n_eff,
	input  rps_pkg::qstat_t               qstat,
	output logic                          busy,
	output logic                          push,
	output rps_pkg::qitem_t               item
);
	import rps_pkg::*;

	localparam int CW  = $clog2(N+1);
	localparam int DCW = $clog2(WORD_W);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t              state_q;
	logic [CW-1:0]        fill_q;
	logic [WORD_W-1:0]    word_q;
	logic [VAL_W-1:0]     rem_q;
	logic [CW-1:0]        bound_q;
	logic [DCW-1:0]       cnt_q;

	logic [VAL_W:0]       trial;
	logic [VAL_W:0]       diff;
	logic [WORD_W:0]      blk_end;
	logic                 rejected;
	logic                 is_last;

	// One restoring division step per cycle, most significant bit first.
	assign trial = {rem_q, word_q[cnt_q]};
	assign diff  = trial - (VAL_W+1)'(bound_q);

	// The word is biased when the end of its quotient block passes the word range.
	assign blk_end  = {1'b0, word_q} - (WORD_W+1)'(rem_q) + (WORD_W+1)'(bound_q);
	assign rejected = blk_end > WORD_RANGE;
	assign is_last  = (fill_q == n_eff - CW'(1));

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_DONE) && !rejected && !qstat.full;

	// Classified draw handed to the back.
	always_comb begin
		item         = '0;
		item.pos     = POS_W'(fill_q);
		item.val     = VAL_W'(fill_q) + rem_q;
		item.is_last = is_last;
	end

	// Sequencer and fill position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) state_q <= F_DIV;
				end
				F_DIV: begin
					if (cnt_q == '0) state_q <= F_DONE;
				end
				F_DONE: begin
					if (rejected || !qstat.full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg_we) begin
				fill_q <= '0;
			end else if (push) begin
				fill_q <= is_last ? '0 : fill_q + CW'(1);
			end
		end
	end

	// Word, remainder and bound of the draw in progress.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			word_q  <= rnd_word;
			rem_q   <= '0;
			bound_q <= n_eff - fill_q;
			cnt_q   <= DCW'(WORD_W-1);
		end else if (state_q == F_DIV) begin
			rem_q <= (trial >= (VAL_W+1)'(bound_q)) ? VAL_W'(diff) : VAL_W'(trial);
			cnt_q <= cnt_q - DCW'(1);
		end
	end

endmodule

/* hw/rtl/rps_queue.sv */
// Small FIFO that carries accepted draws from the front to the back.
module rps_queue #(
	parameter int DEPTH = rps_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rps_pkg::qitem_t   item_in,
	input  logic              pop,
	output rps_pkg::qitem_t   item_out,
	output rps_pkg::qstat_t   qstat
);
	import rps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH+1);

	qitem_t         slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign item_out    = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == NW'(DEPTH));
	assign qstat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= item_in;
	end

endmodule

/* hw/rtl/rps_back.sv */
// Back end: fills the entry store, runs the duplicate conversion and streams the result.
module rps_back #(
	parameter int N = rps_pkg::N_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(N+1)-1:0]      n_eff,
	input  rps_pkg::qstat_t             qstat,
	input  rps_pkg::qitem_t             item,
	output logic                        pop,
	output logic                        idle,
	output logic                        result_strobe,
	output logic [rps_pkg::POS_W-1:0]   position,
	output logic [rps_pkg::VAL_W-1:0]   perm_value,
	output logic                        last
);
	import rps_pkg::*;

	localparam int AW = $clog2(N);
	localparam int CW = $clog2(N+1);

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_RDI   = 6'b000010,
		B_LDI   = 6'b000100,
		B_SWEEP = 6'b001000,
		B_DRAIN = 6'b010000,
		B_EMIT  = 6'b100000
	} bstate_t;

	bstate_t            state_q;
	logic [VAL_W-1:0]   entry_store_q [N];
	logic [VAL_W-1:0]   rd_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      k_q;
	logic [VAL_W-1:0]   vi_q;
	logic               chk_s1;
	logic [AW-1:0]      j_s1;
	logic               em_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               last_s1;

	logic [AW-1:0]      top_idx;
	logic               re;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VAL_W-1:0]   wdata;
	logic               hit;

	assign top_idx = AW'(n_eff - CW'(1));
	assign pop     = (state_q == B_IDLE) && !qstat.empty;
	assign idle    = (state_q == B_IDLE) && !em_s1;
	assign hit     = chk_s1 && (rd_q == vi_q);

	// Read port: entry i, the sweep index j, or the emit index k.
	always_comb begin
		re    = 1'b0;
		raddr = k_q;
		unique case (state_q)
			B_RDI:   begin re = 1'b1; raddr = i_q; end
			B_SWEEP: begin re = 1'b1; raddr = j_q; end
			B_EMIT:  begin re = 1'b1; raddr = k_q; end
			default: begin re = 1'b0; raddr = k_q; end
		endcase
	end

	// Write port: a new draw, or a later duplicate folded onto index i.
	always_comb begin
		we    = 1'b0;
		waddr = j_s1;
		wdata = VAL_W'(i_q);
		if (pop) begin
			we    = 1'b1;
			waddr = item.pos[AW-1:0];
			wdata = item.val;
		end else if (hit) begin
			we = 1'b1;
		end
	end

	// Entry store with registered read data.
	always_ff @(posedge clk) begin
		if (we) entry_store_q[waddr] <= wdata;
		if (re) rd_q <= entry_store_q[raddr];
	end

	// Conversion and emit sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			chk_s1  <= 1'b0;
			em_s1   <= 1'b0;
		end else begin
			chk_s1 <= (state_q == B_SWEEP);
			em_s1  <= (state_q == B_EMIT);
			unique case (state_q)
				B_IDLE: begin
					if (pop && item.is_last) state_q <= B_RDI;
				end
				B_RDI: state_q <= B_LDI;
				B_LDI: begin
					if (i_q != top_idx) begin
						state_q <= B_SWEEP;
					end else if (i_q == '0) begin
						state_q <= B_EMIT;
					end else begin
						state_q <= B_RDI;
					end
				end
				B_SWEEP: begin
					if (j_q == top_idx) state_q <= B_DRAIN;
				end
				B_DRAIN: begin
					state_q <= (i_q == '0) ? B_EMIT : B_RDI;
				end
				B_EMIT: begin
					if (k_q == top_idx) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Loop indices and output pipeline.
	always_ff @(posedge clk) begin
		j_s1    <= j_q;
		pos_s1  <= POS_W'(k_q);
		last_s1 <= (k_q == top_idx);
		unique case (state_q)
			B_IDLE: begin
				i_q <= top_idx;
				k_q <= '0;
			end
			B_LDI: begin
				vi_q <= rd_q;
				j_q  <= i_q + AW'(1);
				if (i_q == top_idx && i_q != '0) i_q <= i_q - AW'(1);
			end
			B_SWEEP: begin
				j_q <= j_q + AW'(1);
			end
			B_DRAIN: begin
				if (i_q != '0) i_q <= i_q - AW'(1);
			end
			B_EMIT: begin
				k_q <= k_q + AW'(1);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign result_strobe = em_s1;
	assign position      = pos_s1;
	assign perm_value    = rd_q;
	assign last          = em_s1 && last_s1;

endmodule

/* hw/rtl/random_permutation_sampler.sv */
// Top level of the random permutation sampler.
//
// Accepted random words are run through the front's remainder unit, one
// bit per cycle, and then decided on. busy is high from the accept until
// that decision is made, and stays high while the decision waits on a full
// queue. start is taken only while busy is low. Words that would bias the
// draw are dropped without a result. When the last position of a
// permutation is filled, the back walks the entry store to fold duplicate
// values, using its single read and single write port. It then puts out the
// n entries on consecutive cycles, one result per cycle marked by
// result_strobe, with last on the final entry. The receiver cannot stall
// results. A four-beat queue lets the front keep taking words for the next
// permutation during conversion. A write on the configuration channel sets
// the entry count (clamped to 2..N) and restarts the permutation. cfg_ready
// is high only when the block has no work in flight and no word is being
// offered on start.
module random_permutation_sampler #(
	parameter int N = rps_pkg::N_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rps_pkg::WORD_W-1:0]  rnd_word,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rps_pkg::CFG_W-1:0]   cfg_data,
	output logic                        result_strobe,
	output logic [rps_pkg::POS_W-1:0]   position,
	output logic [rps_pkg::VAL_W-1:0]   perm_value,
	output logic                        last
);
	import rps_pkg::*;

	localparam int CW = $clog2(N+1);

	logic [CW-1:0]  n_q;
	logic           cfg_we;
	logic           push;
	logic           pop;
	logic           back_idle;
	qitem_t         push_item;
	qitem_t         head_item;
	qstat_t         qstat;

	// A word offered in the same cycle takes precedence over a register write.
	assign cfg_ready = !busy && !start && qstat.empty && back_idle;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Entry count register, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'((NACT_RESET > N) ? N : NACT_RESET);
		end else if (cfg_we) begin
			priority if (cfg_data < CFG_W'(NACT_MIN)) begin
				n_q <= CW'(NACT_MIN);
			end else if (cfg_data > CFG_W'(N)) begin
				n_q <= CW'(N);
			end else begin
				n_q <= CW'(cfg_data);
			end
		end
	end

	rps_front #(.N(N)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rnd_word (rnd_word),
		.cfg_we   (cfg_we),
		.n_eff    (n_q),
		.qstat    (qstat),
		.busy     (busy),
		.push     (push),
		.item     (push_item)
	);

	rps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (push_item),
		.pop      (pop),
		.item_out (head_item),
		.qstat    (qstat)
	);

	rps_back #(.N(N)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.n_eff         (n_q),
		.qstat         (qstat),
		.item          (head_item),
		.pop           (pop),
		.idle          (back_idle),
		.result_strobe (result_strobe),
		.position      (position),
		.perm_value    (perm_value),
		.last          (last)
	);

endmodule

/* hw/rtl/rps_checker.sv */
// Port-level checks for the random permutation sampler, bound to the top level.
module rps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        result_strobe,
	input logic [rps_pkg::POS_W-1:0]   position,
	input logic [rps_pkg::VAL_W-1:0]   perm_value,
	input logic                        last
);
	import rps_pkg::*;

	// A permutation always starts at position zero.
	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_strobe) |-> position == '0)
		else $error("permutation does not start at position zero");

	// Entries stream on consecutive cycles with rising positions until last.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=>
			result_strobe && position == POS_W'($past(position) + POS_W'(1)))
		else $error("result stream broken before last entry");

	// The last entry's value never exceeds its position.
	a_last_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> perm_value <= position)
		else $error("last entry holds an out-of-range value");

	// Configuration is never offered as ready while results stream.
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !cfg_ready)
		else $error("configuration ready during result stream");

	// Configuration is never ready while a word is being reduced.
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("configuration ready while front is busy");

endmodule

bind random_permutation_sampler rps_checker u_rps_checker (.*);
